/* sv/circular_double_ended_queue_defines.svh */
// Assertion macros shared by the deque RTL.
// Define NO_ASSERTIONS at compile time to strip them.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every clock edge outside reset
`define CDEQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// when pre holds, post must hold in the next cycle
`define CDEQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define CDEQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define CDEQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

/* sv/cdeq_pkg.sv */
// Package for the circular double-ended queue: field widths, operation
// and status codes, controller-to-datapath command type. No dependencies.
package cdeq_pkg;

    localparam int MODE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 4;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic execute;   // run the accepted item against the store
        logic hold;      // result waiting for the sink; keep result registers
    } cdeq_cmd_t;

endpackage

/* sv/cdeq_if.sv */
// Request and response channel interfaces for the deque.
// Depends on cdeq_pkg for field widths.
interface cdeq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [cdeq_pkg::MODE_W-1:0]          mode;
    logic signed [cdeq_pkg::VALUE_W-1:0]  push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface cdeq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [cdeq_pkg::STAT_W-1:0]          status;
    logic signed [cdeq_pkg::VALUE_W-1:0]  popped_value;
    logic [cdeq_pkg::OCC_W-1:0]           occupancy;
    logic                                 is_empty;
    logic                                 is_full;

    modport source (output valid, output status, output popped_value,
                    output occupancy, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input occupancy, input is_empty, input is_full, output ready);
endinterface

/* sv/circular_double_ended_queue.sv */
// Circular double-ended queue of DEPTH signed 32-bit words.
// An item is taken while the controller is idle; its result is valid the next cycle.
// The controller takes no new item until the sink has taken the result, and the
// result registers hold it until then.
// Reset (rst_n, async, active low) empties the queue; slot contents are not
// cleared and no clearing pass is run.
module circular_double_ended_queue #(
    parameter int DEPTH = 8     // 2 .. 15 slots (occupancy output is 4 bits)
) (
    input  logic           clk,
    input  logic           rst_n,
    cdeq_req_if.sink       req,
    cdeq_rsp_if.source     rsp
);

    cdeq_pkg::cdeq_cmd_t cmd;

    // Controller: takes an item when idle, then presents its result until the
    // sink takes it.
    cdeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Datapath: on execute, a push writes one slot and moves one pointer; a pop
    // moves one pointer and reads one slot, the RAM's registered read landing
    // just as the result goes valid. Refused items leave slots, pointers and count as they are.
    cdeq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (req.mode),
        .push_value   (req.push_value),
        .status       (rsp.status),
        .popped_value (rsp.popped_value),
        .occupancy    (rsp.occupancy),
        .is_empty     (rsp.is_empty),
        .is_full      (rsp.is_full)
    );

endmodule

/* sv/cdeq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies. Contents are undefined until written.
module cdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/cdeq_ctrl.sv */
// Deque controller: two-state handshake sequencer, issues commands to the
// datapath. Depends on cdeq_pkg and the assertion macro header.
`include "circular_double_ended_queue_defines.svh"

module cdeq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output cdeq_pkg::cdeq_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;   // waiting for an item
    localparam logic S_RESP = 1'b1;   // result held until taken

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = (state_reg == S_RESP);
    assign cmd.execute = req_valid && req_ready;
    assign cmd.hold    = rsp_valid && !rsp_ready;

    // an executed item always shows a result the next cycle
    `CDEQ_ASSERT_NEXT(a_exec_gives_result, clk, rst_n, cmd.execute, rsp_valid,
        "executed item did not produce a result")
    // an unaccepted result stays presented
    `CDEQ_ASSERT_NEXT(a_hold_keeps_result, clk, rst_n, cmd.hold, rsp_valid && !req_ready,
        "held result dropped or new item taken")

endmodule

/* sv/cdeq_dp.sv */
// Deque datapath: head/tail pointers, occupancy count, slot RAM and result
// registers. Depends on cdeq_pkg, cdeq_ram and the assertion macro header.
`include "circular_double_ended_queue_defines.svh"

module cdeq_dp #(
    parameter int DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cdeq_pkg::cdeq_cmd_t                 cmd,
    input  logic [cdeq_pkg::MODE_W-1:0]         mode,
    input  logic signed [cdeq_pkg::VALUE_W-1:0] push_value,
    output logic [cdeq_pkg::STAT_W-1:0]         status,
    output logic signed [cdeq_pkg::VALUE_W-1:0] popped_value,
    output logic [cdeq_pkg::OCC_W-1:0]          occupancy,
    output logic                                is_empty,
    output logic                                is_full
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [cdeq_pkg::STAT_W-1:0] status_reg, status_next;
    logic             pop_ok_reg, pop_ok_next;

    logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic             is_push, q_empty, q_full;

    logic                           wr_en, rd_en;
    logic [IDX_W-1:0]               wr_addr, rd_addr;
    logic [cdeq_pkg::VALUE_W-1:0]   rd_data;
    logic [CNT_W+cdeq_pkg::OCC_W-1:0] occ_wide;

    // wrap-around neighbours of both pointers
    always_comb
    begin
        head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
        head_dec = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;
        tail_inc = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
        tail_dec = (tail_reg == '0) ? IDX_LAST : tail_reg - 1'b1;
    end

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_FULL);
    assign is_push = (mode == cdeq_pkg::MODE_PUSH_FRONT) ||
                     (mode == cdeq_pkg::MODE_PUSH_BACK);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        if (cmd.execute)
        begin
            status_next = cdeq_pkg::STAT_DONE;
            pop_ok_next = 1'b0;
            if (is_push)
            begin
                if (q_full)
                begin
                    status_next = cdeq_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (mode == cdeq_pkg::MODE_PUSH_FRONT)
                    begin
                        wr_addr   = head_dec;
                        head_next = head_dec;
                    end
                    else
                    begin
                        wr_addr   = tail_reg;
                        tail_next = tail_inc;
                    end
                end
            end
            else
            begin
                if (q_empty)
                begin
                    status_next = cdeq_pkg::STAT_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                    if (mode == cdeq_pkg::MODE_POP_FRONT)
                    begin
                        rd_addr   = head_reg;
                        head_next = head_inc;
                    end
                    else
                    begin
                        rd_addr   = tail_dec;
                        tail_next = tail_dec;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            status_reg <= cdeq_pkg::STAT_DONE;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    cdeq_ram #(
        .WIDTH (cdeq_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign occ_wide     = {{cdeq_pkg::OCC_W{1'b0}}, count_reg};
    assign occupancy    = occ_wide[cdeq_pkg::OCC_W-1:0];
    assign status       = status_reg;
    assign popped_value = pop_ok_reg ? $signed(rd_data) : '0;
    assign is_empty     = q_empty;
    assign is_full      = q_full;

    // distance from head to tail around the ring
    logic [CNT_W:0] ptr_gap;
    always_comb
    begin
        if (tail_reg >= head_reg)
        begin
            ptr_gap = (CNT_W+1)'(tail_reg) - (CNT_W+1)'(head_reg);
        end
        else
        begin
            ptr_gap = (CNT_W+1)'(tail_reg) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(head_reg);
        end
    end

    `CDEQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_FULL,
        "occupancy above depth")
    `CDEQ_ASSERT_ALWAYS(a_ptr_consistent, clk, rst_n,
        (ptr_gap == (CNT_W+1)'(count_reg)) || ((ptr_gap == '0) && q_full),
        "pointers disagree with occupancy")
    `CDEQ_ASSERT_NEXT(a_refused_no_change, clk, rst_n,
        cmd.execute && ((is_push && q_full) || (!is_push && q_empty)),
        $stable(count_reg) && $stable(head_reg) && $stable(tail_reg),
        "refused item changed queue state")

endmodule
